@@ hw/rtl/tls_session_ticket_parser_unit_assert.svh @@
// Assertion macros shared by the session ticket parser RTL.
`ifndef TLS_SESSION_TICKET_PARSER_UNIT_ASSERT_SVH
`define TLS_SESSION_TICKET_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsp assertion failed");
`define TSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsp assertion failed");
`else
`define TSP_ASSERT_IMP(lbl, ante, cons)
`define TSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/tsp_pkg.sv @@
// Types and constants of the session ticket parser.
package tsp_pkg;

    localparam int unsigned MAX_TICKET_BYTES = 1024;
    localparam int unsigned MAX_NONCE_BYTES  = 32;
    localparam int unsigned OUT_DEPTH        = 4;

    localparam logic [15:0] EARLY_DATA_TYPE = 16'd42;
    localparam logic [15:0] EARLY_DATA_LEN  = 16'd4;

    typedef enum logic [1:0] {
        KIND_NONCE,
        KIND_TICKET,
        KIND_SUMMARY
    } kind_t;

    typedef enum logic [3:0] {
        PH_LIFE,
        PH_AGE,
        PH_NLEN,
        PH_NONCE,
        PH_TLEN,
        PH_TICK,
        PH_XLEN,
        PH_XTYPE,
        PH_XLENF,
        PH_EARLY,
        PH_SKIP,
        PH_DONE,
        PH_BAD
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] lifetime;
        logic [31:0] age_add;
        logic [31:0] early_limit;
        logic [5:0]  nonce_length;
        logic [10:0] ticket_length;
        logic        status;
        logic        run_end;
    } result_t;

endpackage

@@ hw/rtl/tsp_parse_core.sv @@
// Input register, parse state and per-byte step logic.
module tsp_parse_core
    import tsp_pkg::*;
#(
    parameter int unsigned NONCE_LIMIT  = MAX_NONCE_BYTES,
    parameter int unsigned TICKET_LIMIT = MAX_TICKET_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    output logic       item_stall,
    input  logic       room,
    output logic [1:0] push_cnt,
    output result_t    res0,
    output result_t    res1
);

    `include "tls_session_ticket_parser_unit_assert.svh"

    logic               in_vld_reg;
    item_t              in_reg;
    logic               fire;

    phase_t             phase_reg,    phase_upd,    phase_next;
    logic [15:0]        fc_reg,       fc_upd,       fc_next;
    logic [31:0]        acc_reg,      acc_upd,      acc_next;
    logic [31:0]        life_reg,     life_upd,     life_next;
    logic [31:0]        age_reg,      age_upd,      age_next;
    logic [31:0]        early_reg,    early_upd,    early_next;
    logic signed [17:0] rem_reg,      rem_upd,      rem_next;
    logic [15:0]        xtype_reg,    xtype_upd,    xtype_next;
    logic [5:0]         ncnt_reg,     ncnt_upd,     ncnt_next;
    logic [10:0]        tcnt_reg,     tcnt_upd,     tcnt_next;
    logic               bad_reg,      bad_upd,      bad_next;
    logic               cmpl_reg,     cmpl_upd,     cmpl_next;

    logic [7:0]         b;
    logic               fin;
    logic [31:0]        acc_sh;
    logic [15:0]        v;
    logic [15:0]        fc_inc;
    logic [15:0]        fc_dec;
    logic signed [17:0] rem_m2;
    logic signed [17:0] rem_m4;
    logic signed [17:0] rem_skip;
    logic               has_byte;
    result_t            byte_res;
    result_t            summ_res;

    assign b      = in_reg.data_byte;
    assign fin    = in_reg.final_byte;
    assign acc_sh = {acc_reg[23:0], b};
    assign v      = acc_sh[15:0];
    assign fc_inc = fc_reg + 16'd1;
    assign fc_dec = fc_reg - 16'd1;
    assign rem_m2 = rem_reg - 18'sd2;
    assign rem_m4 = rem_reg - 18'sd4;
    assign rem_skip = rem_m2 - $signed({2'b00, v});

    assign fire       = in_vld_reg & room;
    assign item_stall = in_vld_reg & ~fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= (item_valid & ~item_stall) | (in_vld_reg & ~fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_reg <= item;
        end
    end

    // next state
    always_comb
    begin
        phase_upd = phase_reg;
        fc_upd    = fc_reg;
        acc_upd   = acc_reg;
        life_upd  = life_reg;
        age_upd   = age_reg;
        early_upd = early_reg;
        rem_upd   = rem_reg;
        xtype_upd = xtype_reg;
        ncnt_upd  = ncnt_reg;
        tcnt_upd  = tcnt_reg;
        bad_upd   = bad_reg;
        cmpl_upd  = cmpl_reg;
        unique case (phase_reg)
            PH_LIFE:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd4)
                begin
                    fc_upd    = '0;
                    life_upd  = acc_sh;
                    acc_upd   = '0;
                    phase_upd = PH_AGE;
                end
            end
            PH_AGE:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd4)
                begin
                    fc_upd    = '0;
                    age_upd   = acc_sh;
                    acc_upd   = '0;
                    phase_upd = PH_NLEN;
                end
            end
            PH_NLEN:
            begin
                if (b > 8'(NONCE_LIMIT))
                begin
                    bad_upd   = 1'b1;
                    phase_upd = PH_BAD;
                end
                else if (b == 8'd0)
                begin
                    phase_upd = PH_TLEN;
                end
                else
                begin
                    fc_upd    = {8'd0, b};
                    phase_upd = PH_NONCE;
                end
            end
            PH_NONCE:
            begin
                ncnt_upd = ncnt_reg + 6'd1;
                fc_upd   = fc_dec;
                if (fc_dec == 16'd0)
                begin
                    phase_upd = PH_TLEN;
                end
            end
            PH_TLEN:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd2)
                begin
                    fc_upd  = '0;
                    acc_upd = '0;
                    if (v > 16'(TICKET_LIMIT))
                    begin
                        bad_upd   = 1'b1;
                        phase_upd = PH_BAD;
                    end
                    else if (v == 16'd0)
                    begin
                        phase_upd = PH_XLEN;
                    end
                    else
                    begin
                        fc_upd    = v;
                        phase_upd = PH_TICK;
                    end
                end
            end
            PH_TICK:
            begin
                tcnt_upd = tcnt_reg + 11'd1;
                fc_upd   = fc_dec;
                if (fc_dec == 16'd0)
                begin
                    phase_upd = PH_XLEN;
                end
            end
            PH_XLEN:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd2)
                begin
                    fc_upd  = '0;
                    acc_upd = '0;
                    rem_upd = $signed({2'b00, v});
                    if (v == 16'd0)
                    begin
                        cmpl_upd  = 1'b1;
                        phase_upd = PH_DONE;
                    end
                    else
                    begin
                        phase_upd = PH_XTYPE;
                    end
                end
            end
            PH_XTYPE:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd2)
                begin
                    fc_upd    = '0;
                    acc_upd   = '0;
                    xtype_upd = v;
                    rem_upd   = rem_m2;
                    phase_upd = PH_XLENF;
                end
            end
            PH_XLENF:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd2)
                begin
                    fc_upd  = '0;
                    acc_upd = '0;
                    if (xtype_reg == EARLY_DATA_TYPE)
                    begin
                        rem_upd = rem_m2;
                        if (v != EARLY_DATA_LEN)
                        begin
                            bad_upd   = 1'b1;
                            phase_upd = PH_BAD;
                        end
                        else
                        begin
                            phase_upd = PH_EARLY;
                        end
                    end
                    else
                    begin
                        rem_upd = rem_skip;
                        if (rem_skip <= 18'sd0)
                        begin
                            cmpl_upd  = 1'b1;
                            phase_upd = PH_DONE;
                        end
                        else if (v == 16'd0)
                        begin
                            phase_upd = PH_XTYPE;
                        end
                        else
                        begin
                            fc_upd    = v;
                            phase_upd = PH_SKIP;
                        end
                    end
                end
            end
            PH_EARLY:
            begin
                acc_upd = acc_sh;
                fc_upd  = fc_inc;
                if (fc_inc >= 16'd4)
                begin
                    fc_upd    = '0;
                    acc_upd   = '0;
                    early_upd = acc_sh;
                    rem_upd   = rem_m4;
                    if (rem_m4 <= 18'sd0)
                    begin
                        cmpl_upd  = 1'b1;
                        phase_upd = PH_DONE;
                    end
                    else
                    begin
                        phase_upd = PH_XTYPE;
                    end
                end
            end
            PH_SKIP:
            begin
                fc_upd = fc_dec;
                if (fc_dec == 16'd0)
                begin
                    phase_upd = PH_XTYPE;
                end
            end
            default:
            begin
            end
        endcase

        // final byte: summary goes out, parser restarts
        phase_next = fin ? PH_LIFE : phase_upd;
        fc_next    = fin ? '0 : fc_upd;
        acc_next   = fin ? '0 : acc_upd;
        life_next  = fin ? '0 : life_upd;
        age_next   = fin ? '0 : age_upd;
        early_next = fin ? '0 : early_upd;
        rem_next   = fin ? '0 : rem_upd;
        xtype_next = fin ? '0 : xtype_upd;
        ncnt_next  = fin ? '0 : ncnt_upd;
        tcnt_next  = fin ? '0 : tcnt_upd;
        bad_next   = fin ? 1'b0 : bad_upd;
        cmpl_next  = fin ? 1'b0 : cmpl_upd;
    end

    // outputs
    always_comb
    begin
        has_byte = (phase_reg == PH_NONCE) || (phase_reg == PH_TICK);

        byte_res              = '0;
        byte_res.kind         = (phase_reg == PH_NONCE) ? KIND_NONCE : KIND_TICKET;
        byte_res.payload_byte = b;

        summ_res               = '0;
        summ_res.kind          = KIND_SUMMARY;
        summ_res.lifetime      = life_upd;
        summ_res.age_add       = age_upd;
        summ_res.early_limit   = early_upd;
        summ_res.nonce_length  = ncnt_upd;
        summ_res.ticket_length = tcnt_upd;
        summ_res.status        = bad_upd | ~cmpl_upd;
        summ_res.run_end       = 1'b1;

        push_cnt = fire ? ({1'b0, has_byte} + {1'b0, fin}) : 2'd0;
        res0     = has_byte ? byte_res : summ_res;
        res1     = summ_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LIFE;
            fc_reg    <= '0;
            acc_reg   <= '0;
            life_reg  <= '0;
            age_reg   <= '0;
            early_reg <= '0;
            rem_reg   <= '0;
            xtype_reg <= '0;
            ncnt_reg  <= '0;
            tcnt_reg  <= '0;
            bad_reg   <= 1'b0;
            cmpl_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            acc_reg   <= acc_next;
            life_reg  <= life_next;
            age_reg   <= age_next;
            early_reg <= early_next;
            rem_reg   <= rem_next;
            xtype_reg <= xtype_next;
            ncnt_reg  <= ncnt_next;
            tcnt_reg  <= tcnt_next;
            bad_reg   <= bad_next;
            cmpl_reg  <= cmpl_next;
        end
    end

    `TSP_ASSERT_NXT(a_fin_restart, fire && fin,
        phase_reg == PH_LIFE && ncnt_reg == 6'd0 && !bad_reg && !cmpl_reg)
    `TSP_ASSERT_IMP(a_bad_phase, phase_reg == PH_BAD, bad_reg && !cmpl_reg)
    `TSP_ASSERT_IMP(a_done_phase, phase_reg == PH_DONE, cmpl_reg && !bad_reg)
    `TSP_ASSERT_IMP(a_byte_first, push_cnt == 2'd2,
        res0.kind != KIND_SUMMARY && res1.kind == KIND_SUMMARY)

endmodule

@@ hw/rtl/tsp_result_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one.
module tsp_result_fifo
    import tsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    res0,
    input  result_t    res1,
    output logic       room,
    output logic       result_valid,
    output result_t    result,
    input  logic       result_stall
);

    `include "tls_session_ticket_parser_unit_assert.svh"

    localparam int unsigned PW = $clog2(OUT_DEPTH);
    localparam int unsigned CW = PW + 1;
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(OUT_DEPTH - 2);
    localparam logic [CW-1:0] DEPTH_C    = CW'(OUT_DEPTH);

    result_t          mem_reg [OUT_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [PW-1:0]    wr_ptr_p1;
    logic             pop;

    assign wr_ptr_p1    = wr_ptr_reg + PW'(1);
    assign result_valid = (count_reg != '0);
    assign result       = mem_reg[rd_ptr_reg];
    assign pop          = result_valid & ~result_stall;
    assign room         = (count_reg <= ROOM_LIMIT);

    assign wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(push_cnt) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TSP_ASSERT_IMP(a_no_overflow, push_cnt != 2'd0,
        count_reg + CW'(push_cnt) <= DEPTH_C)
    `TSP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `TSP_ASSERT_NXT(a_pop_only, pop && push_cnt == 2'd0,
        count_reg == $past(count_reg) - CW'(1))

endmodule

@@ hw/rtl/tls_session_ticket_parser_unit.sv @@
// Top level of the session ticket parser.
//
// Parses a session ticket body that arrives one byte per transaction on
// the item channel; final_byte marks the last byte of a ticket. Nonce and
// ticket bytes come out on the result channel as they pass, and the final
// byte adds a summary transaction (lifetime, age_add, early_limit,
// counts, status) with run_end set. A byte that is both a nonce or ticket
// byte and the final byte gives two results: the byte first, then the
// summary.
// A byte waits in the input register, then its results in the result
// queue. Throughput: one byte per cycle while item_stall is low; a byte
// with two results needs two reads of the single-read queue (four deep).
// The step logic fires only when the queue has two free slots; while the
// result side stalls, the queue fills and then item_stall rises.
// Reset clears the parse state and empties the queue; after each summary
// the parser restarts at the lifetime field.
module tls_session_ticket_parser_unit
    import tsp_pkg::*;
#(
    parameter int unsigned NONCE_LIMIT  = MAX_NONCE_BYTES,
    parameter int unsigned TICKET_LIMIT = MAX_TICKET_BYTES
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_stall,
    output logic    result_valid,
    output result_t result,
    input  logic    result_stall
);

    logic       room;
    logic [1:0] push_cnt;
    result_t    res0;
    result_t    res1;

    tsp_parse_core #(
        .NONCE_LIMIT  (NONCE_LIMIT),
        .TICKET_LIMIT (TICKET_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .room       (room),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    tsp_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .res0         (res0),
        .res1         (res1),
        .room         (room),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

@@ dv/tb_tls_session_ticket_parser_unit.sv @@
// Self-checking testbench for the session ticket parser: directed table, then random tickets.
module tb_tls_session_ticket_parser_unit
    import tsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_MIX = 200;
    localparam int N_DIRECTED = 32;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        result_t    want;
    } dir_row_t;

    localparam result_t SUM_EMPTY_BAD = '{KIND_SUMMARY, 8'h00, 32'h0, 32'h0, 32'h0,
                                          6'd0, 11'd0, 1'b1, 1'b1};
    localparam result_t SUM_LONG_NONCE = '{KIND_SUMMARY, 8'h00, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                           6'd0, 11'd0, 1'b1, 1'b1};
    localparam result_t SUM_LONG_TICKET = '{KIND_SUMMARY, 8'h00, 32'h0000_0001,
                                            32'h8000_0000, 32'h0, 6'd0, 11'd0, 1'b1, 1'b1};

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // lone final byte right after reset
        '{8'hA5, 1'b1, 1'b1, SUM_EMPTY_BAD},
        // nonce length over the limit, then an ignored byte
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h21, 1'b0, 1'b0, '0}, '{8'h7E, 1'b1, 1'b1, SUM_LONG_NONCE},
        // final mark on a nonce byte: byte then summary
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0}, '{8'h80, 1'b1, 1'b0, '0},
        // ticket length 1025
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h04, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b1, SUM_LONG_TICKET}
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    item_t   item = '0;
    logic    item_stall;
    logic    result_valid;
    result_t result;
    logic    result_stall = 1'b0;

    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int good_summaries = 0;
    int bad_summaries = 0;
    int bytes_sent = 0;
    int tickets_sent = 0;
    int items_counted = 0;
    bit calm;

    result_t ticket_out_q[$];
    logic [7:0] msg[$];

    // parser shadow state
    phase_t      p_phase;
    int unsigned p_cnt;
    logic [31:0] p_acc;
    logic [31:0] p_life;
    logic [31:0] p_age;
    logic [31:0] p_early;
    int          p_ext_left;
    logic [15:0] p_ext_type;
    logic [7:0]  p_nonces;
    logic [15:0] p_tickets;
    bit          p_bad;
    bit          p_done;

    result_t got;
    result_t want;

    tls_session_ticket_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    always #2 clk = ~clk;

    assign calm = (cycles % 256) < 40;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        result_stall <= !calm && ($urandom_range(0, 99) < stall_pct);
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, ticket_out_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void clear_parser();
        p_phase = PH_LIFE;
        p_cnt = 0;
        p_acc = '0;
        p_life = '0;
        p_age = '0;
        p_early = '0;
        p_ext_left = 0;
        p_ext_type = '0;
        p_nonces = '0;
        p_tickets = '0;
        p_bad = 1'b0;
        p_done = 1'b0;
    endfunction

    function automatic bit take_field(input logic [7:0] b, input int unsigned n);
        p_acc = {p_acc[23:0], b};
        p_cnt++;
        if (p_cnt >= n)
        begin
            p_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter_bad();
        p_bad = 1'b1;
        p_phase = PH_BAD;
    endfunction

    function automatic void enter_done();
        p_done = 1'b1;
        p_phase = PH_DONE;
    endfunction

    function automatic result_t byte_result(input kind_t k, input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = k;
        r.payload_byte = b;
        return r;
    endfunction

    function automatic void parse_ticket_byte(input item_t it);
        logic [7:0] b;
        logic [15:0] v;
        result_t r;
        b = it.data_byte;
        case (p_phase)
            PH_LIFE:
                if (take_field(b, 4))
                begin
                    p_life = p_acc;
                    p_acc = '0;
                    p_phase = PH_AGE;
                end
            PH_AGE:
                if (take_field(b, 4))
                begin
                    p_age = p_acc;
                    p_acc = '0;
                    p_phase = PH_NLEN;
                end
            PH_NLEN:
                if (b > MAX_NONCE_BYTES)
                    enter_bad();
                else if (b == 0)
                    p_phase = PH_TLEN;
                else
                begin
                    p_cnt = b;
                    p_phase = PH_NONCE;
                end
            PH_NONCE:
            begin
                ticket_out_q.push_back(byte_result(KIND_NONCE, b));
                p_nonces++;
                p_cnt--;
                if (p_cnt == 0)
                    p_phase = PH_TLEN;
            end
            PH_TLEN:
                if (take_field(b, 2))
                begin
                    v = p_acc[15:0];
                    p_acc = '0;
                    if (v > MAX_TICKET_BYTES)
                        enter_bad();
                    else if (v == 0)
                        p_phase = PH_XLEN;
                    else
                    begin
                        p_cnt = v;
                        p_phase = PH_TICK;
                    end
                end
            PH_TICK:
            begin
                ticket_out_q.push_back(byte_result(KIND_TICKET, b));
                p_tickets++;
                p_cnt--;
                if (p_cnt == 0)
                    p_phase = PH_XLEN;
            end
            PH_XLEN:
                if (take_field(b, 2))
                begin
                    p_ext_left = int'(p_acc[15:0]);
                    p_acc = '0;
                    if (p_ext_left == 0)
                        enter_done();
                    else
                        p_phase = PH_XTYPE;
                end
            PH_XTYPE:
                if (take_field(b, 2))
                begin
                    p_ext_type = p_acc[15:0];
                    p_acc = '0;
                    p_ext_left -= 2;
                    p_phase = PH_XLENF;
                end
            PH_XLENF:
                if (take_field(b, 2))
                begin
                    v = p_acc[15:0];
                    p_acc = '0;
                    p_ext_left -= 2;
                    if (p_ext_type == EARLY_DATA_TYPE)
                    begin
                        if (v != EARLY_DATA_LEN)
                            enter_bad();
                        else
                            p_phase = PH_EARLY;
                    end
                    else
                    begin
                        p_ext_left -= int'(v);
                        if (p_ext_left <= 0)
                            enter_done();
                        else if (v == 0)
                            p_phase = PH_XTYPE;
                        else
                        begin
                            p_cnt = v;
                            p_phase = PH_SKIP;
                        end
                    end
                end
            PH_EARLY:
                if (take_field(b, 4))
                begin
                    p_early = p_acc;
                    p_acc = '0;
                    p_ext_left -= int'(EARLY_DATA_LEN);
                    if (p_ext_left <= 0)
                        enter_done();
                    else
                        p_phase = PH_XTYPE;
                end
            PH_SKIP:
            begin
                p_cnt--;
                if (p_cnt == 0)
                    p_phase = PH_XTYPE;
            end
            default: ;
        endcase
        if (it.final_byte)
        begin
            r = '0;
            r.kind = KIND_SUMMARY;
            r.lifetime = p_life;
            r.age_add = p_age;
            r.early_limit = p_early;
            r.nonce_length = p_nonces[5:0];
            r.ticket_length = p_tickets[10:0];
            r.status = p_bad || !p_done;
            r.run_end = 1'b1;
            ticket_out_q.push_back(r);
            clear_parser();
        end
    endfunction

    // called at a rising edge; returns at the edge that takes the transaction
    task automatic send_byte(input item_t it, input bit pinned, input result_t pin_val);
        bit took;
        while (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
        begin
            @(negedge clk);
            took = !item_stall;
            if (took)
            begin
                parse_ticket_byte(it);
                if (pinned)
                    ticket_out_q[ticket_out_q.size() - 1] = pin_val;
            end
            @(posedge clk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic put_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            msg.push_back(v[8 * i +: 8]);
    endtask

    // builds one ticket body in msg; counted excludes the random bytes appended after the body
    task automatic make_ticket(output int counted);
        int sel;
        int nlen;
        int tlen;
        int nx;
        int xlen;
        int elen;
        int pos;
        int cut;
        logic [15:0] xtype;
        msg.delete();
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            repeat ($urandom_range(1, 24))
                msg.push_back(8'($urandom));
            counted = msg.size();
        end
        else
        begin
            put_be($urandom, 4);
            put_be($urandom, 4);
            sel = $urandom_range(0, 99);
            if (sel < 5)
                nlen = $urandom_range(MAX_NONCE_BYTES + 1, 255);
            else if (sel < 15)
                nlen = MAX_NONCE_BYTES;
            else
                nlen = $urandom_range(0, 8);
            msg.push_back(8'(nlen));
            if (nlen <= MAX_NONCE_BYTES)
            begin
                repeat (nlen)
                    msg.push_back(8'($urandom));
                sel = $urandom_range(0, 99);
                if (sel < 1)
                    tlen = MAX_TICKET_BYTES;
                else if (sel < 3)
                    tlen = MAX_TICKET_BYTES + 1;
                else if (sel < 6)
                    tlen = $urandom_range(MAX_TICKET_BYTES + 2, 65535);
                else if (sel < 14)
                    tlen = 0;
                else
                    tlen = $urandom_range(1, 12);
                put_be(tlen, 2);
                if (tlen <= MAX_TICKET_BYTES)
                begin
                    repeat (tlen)
                        msg.push_back(8'($urandom));
                    pos = msg.size();
                    nx = $urandom_range(0, 3);
                    repeat (nx)
                    begin
                        if ($urandom_range(0, 99) < 45)
                        begin
                            xtype = EARLY_DATA_TYPE;
                            elen = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(0, 9);
                        end
                        else
                        begin
                            xtype = 16'($urandom);
                            if (xtype == EARLY_DATA_TYPE)
                                xtype = ~xtype;
                            elen = $urandom_range(0, 6);
                        end
                        put_be(xtype, 2);
                        put_be(elen, 2);
                        repeat (elen)
                            msg.push_back(8'($urandom));
                    end
                    xlen = msg.size() - pos;
                    sel = $urandom_range(0, 99);
                    if (sel < 15)
                        xlen = $urandom_range(0, xlen);
                    else if (sel < 20)
                        xlen = $urandom_range(0, 65535);
                    msg.insert(pos, 8'(xlen));
                    msg.insert(pos, 8'(xlen >> 8));
                end
            end
            counted = msg.size();
            repeat ($urandom_range(0, 2))
                msg.push_back(8'($urandom));
        end
        if ($urandom_range(0, 99) < 15)
        begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut)
                void'(msg.pop_back());
            if (counted > cut)
                counted = cut;
        end
    endtask

    function automatic string show(input result_t r);
        return $sformatf("kind=%0d byte=%h life=%h age=%h early=%h nl=%0d tl=%0d st=%b end=%b",
                         r.kind, r.payload_byte, r.lifetime, r.age_add, r.early_limit,
                         r.nonce_length, r.ticket_length, r.status, r.run_end);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got = result;
            results_seen++;
            if (ticket_out_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: %s", cycles, show(got));
            end
            else
            begin
                want = ticket_out_q.pop_front();
                if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                    got.lifetime !== want.lifetime || got.age_add !== want.age_add ||
                    got.early_limit !== want.early_limit ||
                    got.nonce_length !== want.nonce_length ||
                    got.ticket_length !== want.ticket_length ||
                    got.status !== want.status || got.run_end !== want.run_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
                if (want.kind == KIND_SUMMARY)
                begin
                    if (want.status)
                        bad_summaries++;
                    else
                        good_summaries++;
                end
            end
        end
    end

    initial
    begin
        int idle_mix [4];
        int stall_mix [4];
        int counted;
        item_t it;
        idle_mix = '{0, 81, 0, 36};
        stall_mix = '{0, 0, 81, 36};
        clear_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            it.data_byte = DIRECTED[i].data;
            it.final_byte = DIRECTED[i].last;
            send_byte(it, DIRECTED[i].pinned, DIRECTED[i].want);
        end

        for (int mix = 0; mix < 4; mix++)
        begin
            idle_pct = idle_mix[mix];
            stall_pct = stall_mix[mix];
            while (items_counted < ITEMS_PER_MIX * (mix + 1))
            begin
                make_ticket(counted);
                for (int i = 0; i < msg.size(); i++)
                begin
                    it.data_byte = msg[i];
                    it.final_byte = (i == msg.size() - 1);
                    send_byte(it, 1'b0, '0);
                end
                items_counted += counted;
                tickets_sent++;
            end
        end
        item_valid <= 1'b0;

        while (ticket_out_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("%0d random tickets plus directed rows, %0d bytes in, %0d results checked",
                 tickets_sent, bytes_sent, results_seen);
        $display("summaries: %0d parsed fine, %0d bad; %0d mismatches over four idle/stall mixes",
                 good_summaries, bad_summaries, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
